@@ rtl/core/trs_pkg.sv @@
// Shared constants for the triangle row span block.
// No dependencies; compiled before the channel interfaces and the core.
package trs_pkg;

	// Width of the RGB565 colour carried alongside each item.
	localparam int COLOR_BITS = 16;

endpackage : trs_pkg

@@ rtl/core/trs_in_if.sv @@
// Request channel of the triangle row span block: three vertices, a row and a colour.
// Depends on trs_pkg for the colour width.
interface trs_in_if #(
	parameter int COORD_BITS = 11
);
	import trs_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] ax;
	logic signed [COORD_BITS-1:0] ay;
	logic signed [COORD_BITS-1:0] bx;
	logic signed [COORD_BITS-1:0] by_coord;
	logic signed [COORD_BITS-1:0] cx_coord;
	logic signed [COORD_BITS-1:0] cy_coord;
	logic signed [COORD_BITS-1:0] row;
	logic [COLOR_BITS-1:0]        pixel_color;

	modport source (
		output valid, ax, ay, bx, by_coord, cx_coord, cy_coord, row, pixel_color,
		input  ready
	);

	modport sink (
		input  valid, ax, ay, bx, by_coord, cx_coord, cy_coord, row, pixel_color,
		output ready
	);

endinterface : trs_in_if

@@ rtl/core/trs_out_if.sv @@
// Response channel of the triangle row span block: one fill span per item.
// Depends on trs_pkg for the colour width.
interface trs_out_if #(
	parameter int COORD_BITS = 11
);
	import trs_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         valid_res;
	logic signed [COORD_BITS-1:0] span_start;
	logic [COORD_BITS:0]          span_length;
	logic signed [COORD_BITS-1:0] span_row;
	logic [COLOR_BITS-1:0]        span_color;

	modport source (
		output valid, valid_res, span_start, span_length, span_row, span_color,
		input  ready
	);

	modport sink (
		input  valid, valid_res, span_start, span_length, span_row, span_color,
		output ready
	);

endinterface : trs_out_if

@@ rtl/core/triangle_row_span.sv @@
// Triangle row span core: sorts three vertices by y and returns the fill span of one row.
// Depends on trs_pkg and on the channel interfaces trs_in_if and trs_out_if.
//
//   Channel | Modport           | Handshake   | Carries
//   --------+-------------------+-------------+-------------------------------------------
//   req     | trs_in_if.sink    | valid/ready | ax, ay, bx, by_coord, cx_coord, cy_coord,
//           |                   |             | row, pixel_color
//   rsp     | trs_out_if.source | valid/ready | valid_res, span_start, span_length,
//           |                   |             | span_row, span_color
//
// One item is accepted per cycle while req.ready is high; a stall on rsp can hold the flow.
// The two restoring dividers retire one quotient bit per stage.
// Reset clears only the stage valid bits; the data registers are left as they are.
// Each stage loads when it is empty or when the stage after it moves, so a stall on rsp
// fills bubbles first and then holds every item in place; nothing is dropped or repeated.
module triangle_row_span #(
	parameter int COORD_BITS = 11
) (
	input  logic      clk,
	input  logic      arst_n,
	trs_in_if.sink    req,
	trs_out_if.source rsp
);
	import trs_pkg::*;

	localparam int N  = COORD_BITS;
	localparam int PW = 2 * N + 2;

	typedef logic signed [N-1:0]  crd_t;
	typedef logic signed [N:0]    dif_t;
	typedef logic signed [PW-1:0] prod_t;

	// One edge inside the divider: start x, divisor, sign and the running division.
	typedef struct packed {
		logic [N-1:0] xs;
		logic [N:0]   dvs;
		logic         neg;
		logic [N:0]   rem;
		logic [N-1:0] low;
		logic [N-1:0] quo;
	} lane_t;

	typedef struct packed {
		logic                  ok;
		logic [N-1:0]          row;
		logic [COLOR_BITS-1:0] color;
		lane_t                 a;
		lane_t                 b;
	} div_item_t;

	// Sign extension by one bit.
	function automatic dif_t ext(crd_t v);
		return {v[N-1], v};
	endfunction

	// Load a lane from the signed product: magnitude split into the first partial
	// remainder and the dividend bits still to be brought down.
	function automatic lane_t lane_init(prod_t p, crd_t xs, logic [N:0] dvs);
		logic [PW-1:0] mag;
		lane_t         l;
		mag   = p[PW-1] ? -p : p;
		l.xs  = xs;
		l.dvs = dvs;
		l.neg = p[PW-1];
		l.rem = {1'b0, mag[2*N-1:N]};
		l.low = mag[N-1:0];
		l.quo = '0;
		return l;
	endfunction

	// One restoring division step: bring down a bit, subtract when it fits.
	function automatic lane_t lane_step(lane_t l);
		logic [N+1:0] rs;
		logic [N+1:0] rsub;
		logic         ge;
		lane_t        r;
		rs    = {l.rem, l.low[N-1]};
		rsub  = rs - {1'b0, l.dvs};
		ge    = (rs >= {1'b0, l.dvs});
		r     = l;
		r.rem = ge ? rsub[N:0] : rs[N:0];
		r.low = {l.low[N-2:0], 1'b0};
		r.quo = {l.quo[N-2:0], ge};
		return r;
	endfunction

	// Advance both lanes of an item by one quotient bit.
	function automatic div_item_t item_step(div_item_t d);
		div_item_t r;
		r   = d;
		r.a = lane_step(d.a);
		r.b = lane_step(d.b);
		return r;
	endfunction

	// Apply the sign to the quotient and add it to the edge start.
	function automatic crd_t lane_x(lane_t l);
		dif_t q;
		dif_t s;
		q = {1'b0, l.quo};
		if (l.neg) begin
			q = -q;
		end
		s = ext(l.xs) + q;
		return s[N-1:0];
	endfunction

	// Stage handshakes.
	logic       v_s1, v_s2, v_s3, v_s5, v_s6;
	logic       adv_s1, adv_s2, adv_s3, adv_s5, adv_s6;
	logic [N:0] div_v;
	logic [N:0] adv_div;

	// Stage 1: sorted vertices.
	crd_t                  x0_s1, y0_s1, x1_s1, y1_s1, x2_s1, y2_s1, row_s1;
	logic [COLOR_BITS-1:0] color_s1;

	// Stage 2: edge differences.
	logic                  ok_s2;
	crd_t                  row_s2, xsa_s2, xsb_s2;
	logic [COLOR_BITS-1:0] color_s2;
	dif_t                  dxa_s2, dya_s2, dxb_s2, dyb_s2;
	logic [N:0]            dvsa_s2, dvsb_s2;

	// Stage 3: products.
	logic                  ok_s3;
	crd_t                  row_s3, xsa_s3, xsb_s3;
	logic [COLOR_BITS-1:0] color_s3;
	prod_t                 prda_s3, prdb_s3;
	logic [N:0]            dvsa_s3, dvsb_s3;

	// Divider stages; entry 0 holds the loaded lanes.
	div_item_t div_s [0:N];
	div_item_t init_item;

	// Stage 5: edge x positions.
	logic                  ok_s5;
	crd_t                  row_s5, xa_s5, xb_s5;
	logic [COLOR_BITS-1:0] color_s5;

	// Stage 6: output register.
	logic                  ok_s6;
	crd_t                  start_s6, row_s6;
	logic [N:0]            len_s6;
	logic [COLOR_BITS-1:0] color_s6;

	// Backward ready chain.
	always_comb begin
		adv_s6     = !v_s6 || rsp.ready;
		adv_s5     = !v_s5 || adv_s6;
		adv_div[N] = !div_v[N] || adv_s5;
		for (int k = N - 1; k >= 0; k--) begin
			adv_div[k] = !div_v[k] || adv_div[k+1];
		end
		adv_s3 = !v_s3 || adv_div[0];
		adv_s2 = !v_s2 || adv_s3;
		adv_s1 = !v_s1 || adv_s2;
	end

	assign req.ready = adv_s1;

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			div_v <= '0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= req.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
			if (adv_div[0]) begin
				div_v[0] <= v_s3;
			end
			for (int k = 1; k <= N; k++) begin
				if (adv_div[k]) begin
					div_v[k] <= div_v[k-1];
				end
			end
			if (adv_s5) begin
				v_s5 <= div_v[N];
			end
			if (adv_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	// Three compare-and-swap steps put the vertices in ascending y.
	crd_t px0, py0, px1, py1, px2, py2, tmp_x, tmp_y;

	always_comb begin
		px0   = req.ax;
		py0   = req.ay;
		px1   = req.bx;
		py1   = req.by_coord;
		px2   = req.cx_coord;
		py2   = req.cy_coord;
		tmp_x = '0;
		tmp_y = '0;
		if (py1 < py0) begin
			tmp_x = px0; px0 = px1; px1 = tmp_x;
			tmp_y = py0; py0 = py1; py1 = tmp_y;
		end
		if (py2 < py0) begin
			tmp_x = px0; px0 = px2; px2 = tmp_x;
			tmp_y = py0; py0 = py2; py2 = tmp_y;
		end
		if (py2 < py1) begin
			tmp_x = px1; px1 = px2; px2 = tmp_x;
			tmp_y = py1; py1 = py2; py2 = tmp_y;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			x0_s1    <= px0;
			y0_s1    <= py0;
			x1_s1    <= px1;
			y1_s1    <= py1;
			x2_s1    <= px2;
			y2_s1    <= py2;
			row_s1   <= req.row;
			color_s1 <= req.pixel_color;
		end
	end

	// Pick the short edge by the row's side of the middle vertex and form the differences.
	logic ok_c, upper_c;
	crd_t sxs_c, sys_c, sxe_c, sye_c;

	always_comb begin
		ok_c    = (y0_s1 != y2_s1) && (row_s1 >= y0_s1) && (row_s1 <= y2_s1);
		upper_c = row_s1 < y1_s1;
		sxs_c   = upper_c ? x0_s1 : x1_s1;
		sys_c   = upper_c ? y0_s1 : y1_s1;
		sxe_c   = upper_c ? x1_s1 : x2_s1;
		sye_c   = upper_c ? y1_s1 : y2_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			ok_s2    <= ok_c;
			row_s2   <= row_s1;
			color_s2 <= color_s1;
			xsa_s2   <= sxs_c;
			dxa_s2   <= ext(sxe_c) - ext(sxs_c);
			dya_s2   <= ext(row_s1) - ext(sys_c);
			dvsa_s2  <= ext(sye_c) - ext(sys_c) + dif_t'(1);
			xsb_s2   <= x0_s1;
			dxb_s2   <= ext(x2_s1) - ext(x0_s1);
			dyb_s2   <= ext(row_s1) - ext(y0_s1);
			dvsb_s2  <= ext(y2_s1) - ext(y0_s1) + dif_t'(1);
		end
	end

	// One multiplier per edge.
	prod_t prda_c, prdb_c;

	assign prda_c = dxa_s2 * dya_s2;
	assign prdb_c = dxb_s2 * dyb_s2;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			ok_s3    <= ok_s2;
			row_s3   <= row_s2;
			color_s3 <= color_s2;
			xsa_s3   <= xsa_s2;
			xsb_s3   <= xsb_s2;
			prda_s3  <= prda_c;
			prdb_s3  <= prdb_c;
			dvsa_s3  <= dvsa_s2;
			dvsb_s3  <= dvsb_s2;
		end
	end

	// Load the dividers, then one quotient bit per stage.
	always_comb begin
		init_item.ok    = ok_s3;
		init_item.row   = row_s3;
		init_item.color = color_s3;
		init_item.a     = lane_init(prda_s3, xsa_s3, dvsa_s3);
		init_item.b     = lane_init(prdb_s3, xsb_s3, dvsb_s3);
	end

	always_ff @(posedge clk) begin
		if (adv_div[0]) begin
			div_s[0] <= init_item;
		end
		for (int k = 1; k <= N; k++) begin
			if (adv_div[k]) begin
				div_s[k] <= item_step(div_s[k-1]);
			end
		end
	end

	// Signed quotient plus edge start gives each edge's x on the row.
	always_ff @(posedge clk) begin
		if (adv_s5) begin
			ok_s5    <= div_s[N].ok;
			row_s5   <= div_s[N].row;
			color_s5 <= div_s[N].color;
			xa_s5    <= lane_x(div_s[N].a);
			xb_s5    <= lane_x(div_s[N].b);
		end
	end

	// Order the ends and count the pixels; an invalid row reports an empty span.
	crd_t       lo_c, hi_c;
	logic [N:0] len_c;

	always_comb begin
		lo_c  = (xa_s5 > xb_s5) ? xb_s5 : xa_s5;
		hi_c  = (xa_s5 > xb_s5) ? xa_s5 : xb_s5;
		len_c = ext(hi_c) - ext(lo_c) + dif_t'(1);
	end

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			ok_s6    <= ok_s5;
			start_s6 <= ok_s5 ? lo_c : '0;
			len_s6   <= ok_s5 ? len_c : '0;
			row_s6   <= row_s5;
			color_s6 <= color_s5;
		end
	end

	assign rsp.valid       = v_s6;
	assign rsp.valid_res   = ok_s6;
	assign rsp.span_start  = start_s6;
	assign rsp.span_length = len_s6;
	assign rsp.span_row    = row_s6;
	assign rsp.span_color  = color_s6;

	// Whenever the output register can move, the whole pipeline can take an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!rsp.valid || rsp.ready) |-> req.ready)
		else $error("request not ready although the output can drain");

	// An invalid row must report a zero start and length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.valid_res) |-> (rsp.span_start == '0 && rsp.span_length == '0))
		else $error("invalid span carries a non-zero start or length");

	// A valid span always covers at least one pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.valid_res) |-> (rsp.span_length != '0))
		else $error("valid span with zero length");

	// For rows inside the triangle the final remainder stays below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(div_v[N] && div_s[N].ok) |->
			(div_s[N].a.rem < div_s[N].a.dvs && div_s[N].b.rem < div_s[N].b.dvs))
		else $error("divider remainder out of range");

endmodule : triangle_row_span
